// File: hdl/baro_temp_pressure_compensate_macros.svh
// Assertion macros for the barometric compensation block
`ifndef BARO_TEMP_PRESSURE_COMPENSATE_MACROS_SVH
`define BARO_TEMP_PRESSURE_COMPENSATE_MACROS_SVH

// checked outside reset
`define BTPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define BTPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hdl/btpc_pkg.sv
// Package: types and constants of the barometric compensation block
`timescale 1ns / 1ps
package btpc_pkg;

  localparam int unsigned RAW_W     = 20;
  localparam int unsigned TEMP_W    = 16;
  localparam int unsigned PRES_W    = 32;
  localparam int unsigned CFG_N     = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned DIV_N     = 64;
  localparam int unsigned DEN_W     = 31;
  localparam int unsigned FRONT_N   = 10;
  localparam int unsigned BACK_N    = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_T1_T2 = 3'd0,
    REG_T3_P1 = 3'd1,
    REG_P2_P3 = 3'd2,
    REG_P4_P5 = 3'd3,
    REG_P6_P7 = 3'd4,
    REG_P8_P9 = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [RAW_W-1:0] raw_temperature;
    logic [RAW_W-1:0] raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_centidegrees;
    logic [PRES_W-1:0]        pressure_q24_8;
    logic                     pressure_valid;
  } out_item_t;

  // travels with an item through the divider
  typedef struct packed {
    logic signed [TEMP_W-1:0] tc;
    logic                     neg;
    logic                     ok;
  } side_t;

endpackage

// File: hdl/btpc_div.sv
// Pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module btpc_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [btpc_pkg::WORD_W-1:0]  num_i,
  input  logic [btpc_pkg::DEN_W-1:0]   den_i,
  input  btpc_pkg::side_t              side_i,
  output logic                         valid_o,
  output logic [btpc_pkg::WORD_W-1:0]  quot_o,
  output btpc_pkg::side_t              side_o
);

  logic [btpc_pkg::WORD_W-1:0] w_q   [btpc_pkg::DIV_N];
  logic [btpc_pkg::DEN_W-2:0]  r_q   [btpc_pkg::DIV_N];
  logic [btpc_pkg::DEN_W-1:0]  den_q [btpc_pkg::DIV_N];
  btpc_pkg::side_t             side_q[btpc_pkg::DIV_N];
  logic [btpc_pkg::DIV_N-1:0]  v_q;

  for (genvar k = 0; k < btpc_pkg::DIV_N; k++) begin : g_stage
    logic [btpc_pkg::WORD_W-1:0] w_prev;
    logic [btpc_pkg::DEN_W-2:0]  r_prev;
    logic [btpc_pkg::DEN_W-1:0]  den_prev;
    btpc_pkg::side_t             side_prev;
    logic                        v_prev;
    logic [btpc_pkg::DEN_W-1:0]  trial;
    logic [btpc_pkg::DEN_W-1:0]  diff;
    logic                        ge;

    if (k == 0) begin : g_first
      assign w_prev    = num_i;
      assign r_prev    = '0;
      assign den_prev  = den_i;
      assign side_prev = side_i;
      assign v_prev    = valid_i;
    end else begin : g_next
      assign w_prev    = w_q[k-1];
      assign r_prev    = r_q[k-1];
      assign den_prev  = den_q[k-1];
      assign side_prev = side_q[k-1];
      assign v_prev    = v_q[k-1];
    end

    always_comb begin
      trial = {r_prev, w_prev[btpc_pkg::WORD_W-1]};
      ge    = (trial >= den_prev);
      diff  = trial - den_prev;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        w_q[k]    <= {w_prev[btpc_pkg::WORD_W-2:0], ge};
        r_q[k]    <= ge ? diff[btpc_pkg::DEN_W-2:0] : trial[btpc_pkg::DEN_W-2:0];
        den_q[k]  <= den_prev;
        side_q[k] <= side_prev;
      end
    end
  end

  assign valid_o = v_q[btpc_pkg::DIV_N-1];
  assign quot_o  = w_q[btpc_pkg::DIV_N-1];
  assign side_o  = side_q[btpc_pkg::DIV_N-1];

endmodule

// File: hdl/baro_temp_pressure_compensate.sv
// Top level: barometric temperature and pressure compensation pipeline
//
// Input channel in_valid_i/in_ready_o carries one item: raw 20-bit temperature
// and pressure readings. Output channel out_valid_o/out_ready_i gives one item
// per input: temperature in 0.01 degC, pressure in Pa as Q24.8, and a flag that
// is low (with pressure zero) when the pressure divisor is zero.
// Calibration coefficients are written through cfg_valid_i/cfg_index_i/
// cfg_data_i, always ready; write only while no item is in flight.
// The pipeline has 80 register stages: 10 front stages of temperature and
// polynomial math, 64 stages of the quotient unit (one quotient bit per
// stage), 6 back stages ending in the output register. Throughput is one item
// per cycle while the receiver does not stall.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_ready_o drops; nothing is lost or repeated.
// Reset clears all valid bits and the coefficients to zero.
`timescale 1ns / 1ps
`include "baro_temp_pressure_compensate_macros.svh"
module baro_temp_pressure_compensate (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  btpc_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output btpc_pkg::out_item_t             out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [btpc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [btpc_pkg::CFG_W-1:0]      cfg_data_i
);

  logic [btpc_pkg::CFG_W-1:0] cfg_q [btpc_pkg::CFG_N];
  logic en;
  logic [btpc_pkg::FRONT_N-1:0] vf_q;
  logic [btpc_pkg::BACK_N-1:0]  vb_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < btpc_pkg::CFG_N; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_valid_i && (32'(cfg_index_i) < btpc_pkg::CFG_N)) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = cfg_q[btpc_pkg::REG_T1_T2][15:0];
  assign t2 = cfg_q[btpc_pkg::REG_T1_T2][31:16];
  assign t3 = cfg_q[btpc_pkg::REG_T3_P1][15:0];
  assign p1 = cfg_q[btpc_pkg::REG_T3_P1][31:16];
  assign p2 = cfg_q[btpc_pkg::REG_P2_P3][15:0];
  assign p3 = cfg_q[btpc_pkg::REG_P2_P3][31:16];
  assign p4 = cfg_q[btpc_pkg::REG_P4_P5][15:0];
  assign p5 = cfg_q[btpc_pkg::REG_P4_P5][31:16];
  assign p6 = cfg_q[btpc_pkg::REG_P6_P7][15:0];
  assign p7 = cfg_q[btpc_pkg::REG_P6_P7][31:16];
  assign p8 = cfg_q[btpc_pkg::REG_P8_P9][15:0];
  assign p9 = cfg_q[btpc_pkg::REG_P8_P9][31:16];

  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= '0;
    end else if (en) begin
      vf_q <= {vf_q[btpc_pkg::FRONT_N-2:0], in_valid_i};
    end
  end

  // stage 1: temperature products
  logic signed [17:0] dt1;
  logic signed [16:0] dd;
  logic signed [33:0] s1_ma_d, s1_ma_q, s1_dd_d, s1_dd_q;
  logic [btpc_pkg::RAW_W-1:0] s1_adcp_q;
  assign dt1 = $signed({1'b0, in_item_i.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign dd  = $signed({1'b0, in_item_i.raw_temperature[19:4]}) - $signed({1'b0, t1});
  assign s1_ma_d = dt1 * t2;
  assign s1_dd_d = dd * dd;

  // stage 2
  logic signed [22:0] s2_ta_d, s2_ta_q;
  logic signed [21:0] ddsh;
  logic signed [37:0] s2_tbm_d, s2_tbm_q;
  logic [btpc_pkg::RAW_W-1:0] s2_adcp_q;
  assign s2_ta_d  = 23'(s1_ma_q >>> 11);
  assign ddsh     = 22'(s1_dd_q >>> 12);
  assign s2_tbm_d = ddsh * t3;

  // stage 3: fine temperature
  logic signed [24:0] s3_fine_d, s3_fine_q;
  logic [btpc_pkg::RAW_W-1:0] s3_adcp_q;
  assign s3_fine_d = 25'(s2_ta_q) + 25'(s2_tbm_q >>> 14);

  // stage 4: centidegrees and pressure offset
  logic signed [27:0] t5, tcs;
  logic signed [15:0] s4_tc_d, s4_tc_q;
  logic signed [25:0] s4_a_d, s4_a_q;
  logic [btpc_pkg::RAW_W-1:0] s4_adcp_q;
  always_comb begin
    t5  = 28'(s3_fine_q) * 28'sd5 + 28'sd128;
    tcs = t5 >>> 8;
    if (tcs > 28'sd32767) begin
      s4_tc_d = 16'sh7fff;
    end else if (tcs < -28'sd32768) begin
      s4_tc_d = 16'sh8000;
    end else begin
      s4_tc_d = 16'(tcs);
    end
  end
  assign s4_a_d = 26'(s3_fine_q) - 26'sd128000;

  // stage 5
  logic signed [51:0] s5_aa_d, s5_aa_q;
  logic signed [41:0] s5_ap5_d, s5_ap5_q, s5_ap2_d, s5_ap2_q;
  logic signed [15:0] s5_tc_q;
  logic [btpc_pkg::RAW_W-1:0] s5_adcp_q;
  assign s5_aa_d  = s4_a_q * s4_a_q;
  assign s5_ap5_d = s4_a_q * p5;
  assign s5_ap2_d = s4_a_q * p2;

  // stage 6
  logic signed [63:0] s6_b6_d, s6_b6_q, s6_b3_d, s6_b3_q;
  logic signed [41:0] s6_ap5_q, s6_ap2_q;
  logic signed [15:0] s6_tc_q;
  logic [btpc_pkg::RAW_W-1:0] s6_adcp_q;
  assign s6_b6_d = s5_aa_q * p6;
  assign s6_b3_d = s5_aa_q * p3;

  // stage 7
  logic signed [63:0] ap5x, ap2x, p4x;
  logic signed [63:0] s7_b_d, s7_b_q, s7_x_d, s7_x_q;
  logic signed [15:0] s7_tc_q;
  logic [btpc_pkg::RAW_W-1:0] s7_adcp_q;
  assign ap5x   = 64'(s6_ap5_q);
  assign ap2x   = 64'(s6_ap2_q);
  assign p4x    = 64'(p4);
  assign s7_b_d = s6_b6_q + (ap5x <<< 17) + (p4x <<< 35);
  assign s7_x_d = (64'sd1 <<< 47) + (s6_b3_q >>> 8) + (ap2x <<< 12);

  // stage 8
  logic [20:0] pd;
  logic signed [63:0] s8_xp_d, s8_xp_q;
  logic [63:0] s8_n_d, s8_n_q;
  logic signed [15:0] s8_tc_q;
  assign pd      = 21'd1048576 - {1'b0, s7_adcp_q};
  assign s8_xp_d = s7_x_q * $signed({48'd0, p1});
  assign s8_n_d  = $signed({12'd0, pd, 31'd0}) - s7_b_q;

  // stage 9
  logic signed [btpc_pkg::DEN_W-1:0] s9_den_d, s9_den_q;
  logic [63:0] s9_num_d, s9_num_q;
  logic signed [15:0] s9_tc_q;
  assign s9_den_d = btpc_pkg::DEN_W'(s8_xp_q >>> 33);
  assign s9_num_d = s8_n_q * 64'd3125;

  // stage 10: magnitudes for the divider
  logic [63:0] s10_num_q;
  logic [btpc_pkg::DEN_W-1:0] s10_den_q;
  btpc_pkg::side_t s10_side_d, s10_side_q;
  assign s10_side_d.tc  = s9_tc_q;
  assign s10_side_d.neg = s9_num_q[63] ^ s9_den_q[btpc_pkg::DEN_W-1];
  assign s10_side_d.ok  = (s9_den_q != '0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ma_q   <= s1_ma_d;
      s1_dd_q   <= s1_dd_d;
      s1_adcp_q <= in_item_i.raw_pressure;
      s2_ta_q   <= s2_ta_d;
      s2_tbm_q  <= s2_tbm_d;
      s2_adcp_q <= s1_adcp_q;
      s3_fine_q <= s3_fine_d;
      s3_adcp_q <= s2_adcp_q;
      s4_tc_q   <= s4_tc_d;
      s4_a_q    <= s4_a_d;
      s4_adcp_q <= s3_adcp_q;
      s5_aa_q   <= s5_aa_d;
      s5_ap5_q  <= s5_ap5_d;
      s5_ap2_q  <= s5_ap2_d;
      s5_tc_q   <= s4_tc_q;
      s5_adcp_q <= s4_adcp_q;
      s6_b6_q   <= s6_b6_d;
      s6_b3_q   <= s6_b3_d;
      s6_ap5_q  <= s5_ap5_q;
      s6_ap2_q  <= s5_ap2_q;
      s6_tc_q   <= s5_tc_q;
      s6_adcp_q <= s5_adcp_q;
      s7_b_q    <= s7_b_d;
      s7_x_q    <= s7_x_d;
      s7_tc_q   <= s6_tc_q;
      s7_adcp_q <= s6_adcp_q;
      s8_xp_q   <= s8_xp_d;
      s8_n_q    <= s8_n_d;
      s8_tc_q   <= s7_tc_q;
      s9_den_q  <= s9_den_d;
      s9_num_q  <= s9_num_d;
      s9_tc_q   <= s8_tc_q;
      s10_num_q <= s9_num_q[63] ? (64'd0 - s9_num_q) : s9_num_q;
      s10_den_q <= s9_den_q[btpc_pkg::DEN_W-1] ? ('0 - s9_den_q) : s9_den_q;
      s10_side_q <= s10_side_d;
    end
  end

  logic            div_valid;
  logic [63:0]     div_quot;
  btpc_pkg::side_t div_side;

  btpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vf_q[btpc_pkg::FRONT_N-1]),
    .num_i   (s10_num_q),
    .den_i   (s10_den_q),
    .side_i  (s10_side_q),
    .valid_o (div_valid),
    .quot_o  (div_quot),
    .side_o  (div_side)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= '0;
    end else if (en) begin
      vb_q <= {vb_q[btpc_pkg::BACK_N-2:0], div_valid};
    end
  end

  // back stages: polynomial correction of the quotient
  logic signed [63:0] e1_p_q;
  btpc_pkg::side_t    e1_side_q, e2_side_q, e3_side_q, e4_side_q, e5_side_q;
  logic signed [63:0] pr;
  logic [63:0]        e2_ll_d, e2_ll_q;
  logic [31:0]        e2_lh_d, e2_lh_q;
  logic signed [63:0] e2_p8_d, e2_p8_q, e2_p_q;
  logic [63:0]        e3_sq_q;
  logic signed [63:0] e3_p8_q, e3_p_q;
  logic signed [63:0] e4_s9_d, e4_s9_q, e4_p8_q, e4_p_q;
  logic signed [63:0] e5_sum_d, e5_sum_q;
  logic signed [63:0] p7x, rfin;
  btpc_pkg::out_item_t e6_d, e6_q;

  assign pr       = e1_p_q >>> 13;
  assign e2_ll_d  = pr[31:0] * pr[31:0];
  assign e2_lh_d  = pr[31:0] * pr[63:32];
  assign e2_p8_d  = e1_p_q * p8;
  assign e4_s9_d  = $signed(e3_sq_q) * p9;
  assign e5_sum_d = e4_p_q + (e4_s9_q >>> 25) + (e4_p8_q >>> 19);
  assign p7x      = 64'(p7);

  always_comb begin
    rfin = (e5_sum_q >>> 8) + (p7x <<< 4);
    e6_d.temp_centidegrees = e5_side_q.tc;
    e6_d.pressure_valid    = e5_side_q.ok;
    if (!e5_side_q.ok || rfin[63]) begin
      e6_d.pressure_q24_8 = '0;
    end else if (rfin[62:32] != '0) begin
      e6_d.pressure_q24_8 = '1;
    end else begin
      e6_d.pressure_q24_8 = rfin[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_p_q    <= div_side.neg ? (64'sd0 - $signed(div_quot)) : $signed(div_quot);
      e1_side_q <= div_side;
      e2_ll_q   <= e2_ll_d;
      e2_lh_q   <= e2_lh_d;
      e2_p8_q   <= e2_p8_d;
      e2_p_q    <= e1_p_q;
      e2_side_q <= e1_side_q;
      e3_sq_q   <= e2_ll_q + {e2_lh_q[30:0], 1'b0, 32'd0};
      e3_p8_q   <= e2_p8_q;
      e3_p_q    <= e2_p_q;
      e3_side_q <= e2_side_q;
      e4_s9_q   <= e4_s9_d;
      e4_p8_q   <= e3_p8_q;
      e4_p_q    <= e3_p_q;
      e4_side_q <= e3_side_q;
      e5_sum_q  <= e5_sum_d;
      e5_side_q <= e4_side_q;
      e6_q      <= e6_d;
    end
  end

  assign out_valid_o = vb_q[btpc_pkg::BACK_N-1];
  assign out_item_o  = e6_q;

  `BTPC_ASSERT(a_zero_when_invalid, out_valid_o && !out_item_o.pressure_valid |-> out_item_o.pressure_q24_8 == '0, "pressure not zero with divisor zero")
  `BTPC_ASSERT(a_stall_blocks_input, out_valid_o && !out_ready_i |-> !in_ready_o, "input taken while output stalled")
  `BTPC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule
